/* rtl/tab_expand_caret_escape_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the tab expander RTL
// Implication checks, same cycle and next cycle, on the block clock.
// ---------------------------------------------------------------------------
`ifndef TAB_EXPAND_CARET_ESCAPE_MACROS_SVH
`define TAB_EXPAND_CARET_ESCAPE_MACROS_SVH

// same-cycle implication
`define TEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tec_pkg.sv */
// ---------------------------------------------------------------------------
// tec_pkg
// Types and character constants for the tab expander / caret escaper.
// ---------------------------------------------------------------------------
package tec_pkg;

    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_LF      = 8'h0A;
    localparam logic [7:0] C_FF      = 8'h0C;
    localparam logic [7:0] C_ESC     = 8'h1B;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_QMARK   = 8'h3F;
    localparam logic [7:0] C_AT      = 8'h40;
    localparam logic [7:0] C_CARET   = 8'h5E;
    localparam logic [7:0] C_TILDE   = 8'h7E;
    localparam logic [7:0] C_HIGH_LO = 8'hA0;

    localparam logic [6:0] C_TW_RESET = 7'd8;
    localparam logic [6:0] C_TW_MAX   = 7'd64;

    typedef enum logic [1:0] {
        CFG_TAB_WIDTH  = 2'd0,
        CFG_BIG5_MODE  = 2'd1,
        CFG_HIGH_PRINT = 2'd2
    } t_cfg_idx;

    // one queued run of output characters
    typedef struct packed {
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic [6:0] cnt;
        logic       last;
        logic       ff;
    } t_run;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
        logic       form_feed_seen;
    } t_beat;

    function automatic logic [6:0] eff_width(input logic [6:0] w);
        logic [6:0] r;
        if (w == 7'd0) begin
            r = 7'd1;
        end else if (w > C_TW_MAX) begin
            r = C_TW_MAX;
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

/* rtl/tec_if.sv */
// ---------------------------------------------------------------------------
// tec_if
// Valid/ready stream interfaces for input bytes and display characters.
// ---------------------------------------------------------------------------
interface tec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_last;

    modport source (output valid, in_byte, string_last, input ready);
    modport sink   (input valid, in_byte, string_last, output ready);
endinterface

interface tec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic       form_feed_seen;

    modport source (output valid, out_byte, run_last, string_end, form_feed_seen,
                    input ready);
    modport sink   (input valid, out_byte, run_last, string_end, form_feed_seen,
                    output ready);
endinterface

/* rtl/tec_front.sv */
// ---------------------------------------------------------------------------
// tec_front
// Config registers, byte classification and tab-phase tracking; emits one
// run descriptor per accepted byte.
// ---------------------------------------------------------------------------
`include "tab_expand_caret_escape_macros.svh"

module tec_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [6:0]      i_cfg_data,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_ready,
    input  logic            i_full,
    output logic            o_push,
    output tec_pkg::t_run   o_run
);

    logic [6:0] r_tab_width;
    logic       r_big5;
    logic       r_high;
    logic [5:0] r_phase, n_phase;
    logic       r_ff, n_ff;
    logic       r_norm, n_norm;

    logic [6:0] tw, ph7;
    logic [6:0] s_ctrl, s_ctrl1, s_ctrl2, s_pl, s_pl1;
    logic       is_tab, is_lf, is_ctrl, is_print, accept;
    logic [6:0] p_next;

    assign tw  = tec_pkg::eff_width(r_tab_width);
    assign ph7 = {1'b0, r_phase};

    assign o_ready = !r_norm && !i_full && !i_cfg_we;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        is_tab   = (i_byte == tec_pkg::C_TAB);
        is_lf    = (i_byte == tec_pkg::C_LF);
        is_ctrl  = !is_tab && !is_lf && (i_byte < tec_pkg::C_SPACE)
                   && !(r_big5 && (i_byte == tec_pkg::C_ESC));
        is_print = ((i_byte >= tec_pkg::C_SPACE) && (i_byte <= tec_pkg::C_TILDE))
                   || (r_high && (i_byte >= tec_pkg::C_HIGH_LO));

        s_ctrl  = ph7 + 7'd2;
        s_ctrl1 = (s_ctrl >= tw) ? s_ctrl - tw : s_ctrl;
        s_ctrl2 = (s_ctrl1 >= tw) ? s_ctrl1 - tw : s_ctrl1;
        s_pl    = ph7 + 7'd1;
        s_pl1   = (s_pl >= tw) ? s_pl - tw : s_pl;

        o_run.last = i_last;
        o_run.ff   = r_ff || (is_ctrl && (i_byte == tec_pkg::C_FF));
        if (is_tab) begin
            o_run.ch0 = tec_pkg::C_SPACE;
            o_run.ch1 = tec_pkg::C_SPACE;
            o_run.cnt = tw - ph7;
            p_next    = 7'd0;
        end else if (is_ctrl) begin
            o_run.ch0 = tec_pkg::C_CARET;
            o_run.ch1 = i_byte + tec_pkg::C_AT;
            o_run.cnt = 7'd2;
            p_next    = s_ctrl2;
        end else if (is_lf) begin
            o_run.ch0 = i_byte;
            o_run.ch1 = i_byte;
            o_run.cnt = 7'd1;
            p_next    = 7'd0;
        end else begin
            o_run.ch0 = is_print ? i_byte : tec_pkg::C_QMARK;
            o_run.ch1 = o_run.ch0;
            o_run.cnt = 7'd1;
            p_next    = s_pl1;
        end

        n_phase = r_phase;
        n_ff    = r_ff;
        n_norm  = r_norm;
        if (r_norm) begin
            // reduce stored phase after a width change
            if (ph7 >= tw) begin
                n_phase = 6'(ph7 - tw);
            end else begin
                n_norm = 1'b0;
            end
        end else if (accept) begin
            if (i_last) begin
                n_phase = 6'd0;
                n_ff    = 1'b0;
            end else begin
                n_phase = p_next[5:0];
                n_ff    = o_run.ff;
            end
        end
        if (i_cfg_we && (tec_pkg::t_cfg_idx'(i_cfg_idx) == tec_pkg::CFG_TAB_WIDTH)) begin
            n_norm = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width <= tec_pkg::C_TW_RESET;
            r_big5      <= 1'b0;
            r_high      <= 1'b0;
            r_phase     <= 6'd0;
            r_ff        <= 1'b0;
            r_norm      <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ff    <= n_ff;
            r_norm  <= n_norm;
            if (i_cfg_we) begin
                unique case (tec_pkg::t_cfg_idx'(i_cfg_idx))
                    tec_pkg::CFG_TAB_WIDTH:  r_tab_width <= i_cfg_data;
                    tec_pkg::CFG_BIG5_MODE:  r_big5      <= i_cfg_data[0];
                    tec_pkg::CFG_HIGH_PRINT: r_high      <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    `TEC_ASSERT_IMP(a_phase_in_range, i_clk, i_rst_n, !r_norm, ph7 < tw, "phase not below tab width")

endmodule

/* rtl/tec_queue.sv */
// ---------------------------------------------------------------------------
// tec_queue
// Two-entry run descriptor queue between classifier and expander.
// ---------------------------------------------------------------------------
`include "tab_expand_caret_escape_macros.svh"

module tec_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tec_pkg::t_run   i_run,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tec_pkg::t_run   o_head
);

    tec_pkg::t_run r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    `TEC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != 2'd0, "pop from empty queue")
    `TEC_ASSERT_NXT(a_drain_one, i_clk, i_rst_n, r_count == 2'd1 && i_pop && !i_push, r_count == 2'd0, "queue count off after last pop")

endmodule

/* rtl/tec_back.sv */
// ---------------------------------------------------------------------------
// tec_back
// Expands each queued run into display characters, one beat per cycle while
// the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
`include "tab_expand_caret_escape_macros.svh"

module tec_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tec_pkg::t_run   i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output tec_pkg::t_beat  o_beat
);

    logic [5:0]     r_idx, n_idx;
    logic           r_valid;
    tec_pkg::t_beat r_beat, n_beat;
    logic           load, beat_last;
    logic [6:0]     idx7;

    assign idx7      = {1'b0, r_idx};
    assign load      = i_q_valid && (!r_valid || i_ready);
    assign beat_last = (idx7 == i_head.cnt - 7'd1);
    assign o_pop     = load && beat_last;
    assign o_valid   = r_valid;
    assign o_beat    = r_beat;

    always_comb begin
        n_beat.out_byte       = (r_idx == 6'd0) ? i_head.ch0 : i_head.ch1;
        n_beat.run_last       = beat_last;
        n_beat.string_end     = beat_last && i_head.last;
        n_beat.form_feed_seen = beat_last && i_head.last && i_head.ff;
        n_idx                 = beat_last ? 6'd0 : r_idx + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 6'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    `TEC_ASSERT_IMP(a_idx_in_run, i_clk, i_rst_n, i_q_valid, idx7 < i_head.cnt, "beat index past run length")
    `TEC_ASSERT_IMP(a_end_is_run_last, i_clk, i_rst_n, r_valid && r_beat.string_end, r_beat.run_last, "string end off run boundary")

endmodule

/* rtl/tab_expand_caret_escape.sv */
// ---------------------------------------------------------------------------
// tab_expand_caret_escape
// Tab expansion and caret escaping of a byte stream, one display character
// per output beat.
// ---------------------------------------------------------------------------
// Input channel i_in: one text byte per beat, string_last on the final byte.
// Output channel o_out: one display character per beat; run_last marks the
// last character caused by an input byte, string_end the last of a string,
// form_feed_seen (with string_end) whether the string held a form feed.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write tab_width (0), big5_mode (1)
// and high_bytes_printable (2); write only while the block is idle.
// Accepted bytes pass through the queue to the registered output stage.
// Throughput: one byte per cycle for bytes giving one character, while o_out
// is ready and no config write holds input off; a control byte gives two
// characters and a tab (effective tab width - phase) spaces, the expander
// emitting one character a cycle. A two-entry queue lets the input keep
// accepting while a run drains, then input stalls until a slot frees.
// A tab_width write reduces the stored phase by repeated subtraction, with
// input held off until it is done.
// Reset clears registers to tab_width 8, both modes off, phase and form-feed
// flag clear, queue and output empty. An output stall holds the beat and
// backs up through the queue to i_in.ready.
// ---------------------------------------------------------------------------
module tab_expand_caret_escape (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    tec_in_if.sink      i_in,
    tec_out_if.source   o_out
);

    logic           full, push, pop, q_valid, out_valid;
    tec_pkg::t_run  run, head;
    tec_pkg::t_beat beat;

    tec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in.valid),
        .i_byte     (i_in.in_byte),
        .i_last     (i_in.string_last),
        .o_ready    (i_in.ready),
        .i_full     (full),
        .o_push     (push),
        .o_run      (run)
    );

    tec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    tec_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (out_valid),
        .i_ready   (o_out.ready),
        .o_beat    (beat)
    );

    assign o_out.valid          = out_valid;
    assign o_out.out_byte       = beat.out_byte;
    assign o_out.run_last       = beat.run_last;
    assign o_out.string_end     = beat.string_end;
    assign o_out.form_feed_seen = beat.form_feed_seen;

endmodule

/* sim/tab_expand_caret_escape_tb.sv */
// ---------------------------------------------------------------------------
// tab_expand_caret_escape_tb
// Self-checking bench for the tab expander / caret escaper. Text bytes are
// queued by a stimulus sequence and driven beat by beat; every accepted byte
// is run through a local expansion model that queues the display characters
// it should produce, and each output beat is checked against the oldest one.
// Register settings change between phases, once the block has drained.
// ---------------------------------------------------------------------------
module tab_expand_caret_escape_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED    = 2'd3;
    localparam int         IDLE_PCT      = 23;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         MAX_ERR_LINES = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_item;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [6:0] i_cfg_data;

    tec_in_if  in_ch ();
    tec_out_if out_ch ();

    tab_expand_caret_escape i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // stimulus and expected display characters
    t_text_item     text_q [$];
    tec_pkg::t_beat display_q [$];
    t_text_item     next_item;
    bit             in_taken;
    bit             calm;

    // local copy of the block's registers and state
    logic [6:0] tab_width_r;
    logic       big5_r;
    logic       high_print_r;
    logic [5:0] col_phase;
    logic       ff_pending;

    int err_count;
    int n_bytes;
    int n_tabs;
    int n_chars;
    int n_strings;
    int stall_cycles;

    always #2 i_clk = ~i_clk;

    task automatic flag_error(input string what);
        if (err_count < MAX_ERR_LINES) begin
            $display("ERROR @%0t: %s", $realtime, what);
        end
        err_count++;
    endtask

    function automatic bit shown_as_is(input logic [7:0] c);
        return (c >= tec_pkg::C_SPACE && c <= tec_pkg::C_TILDE)
               || (high_print_r && c >= tec_pkg::C_HIGH_LO);
    endfunction

    // expand one accepted byte into its display characters
    task automatic expand_byte(input logic [7:0] c, input logic last);
        logic [7:0]     chars [0:63];
        logic [6:0]     tw;
        logic [6:0]     p;
        tec_pkg::t_beat b;
        int             n;
        int             k;
        n = 0;
        if (tab_width_r == 7'd0) begin
            tw = 7'd1;
        end else if (tab_width_r > tec_pkg::C_TW_MAX) begin
            tw = tec_pkg::C_TW_MAX;
        end else begin
            tw = tab_width_r;
        end
        p = {1'b0, col_phase} % tw;
        if (c == tec_pkg::C_TAB) begin
            for (k = 0; k < int'(tw - p); k++) begin
                chars[n] = tec_pkg::C_SPACE;
                n++;
            end
            p = 7'd0;
        end else if (c < tec_pkg::C_SPACE && c != tec_pkg::C_LF
                     && !(big5_r && c == tec_pkg::C_ESC)) begin
            chars[0] = tec_pkg::C_CARET;
            chars[1] = c + tec_pkg::C_AT;
            n = 2;
            if (c == tec_pkg::C_FF) begin
                ff_pending = 1'b1;
            end
            p = (p + 7'd2) % tw;
        end else if (c == tec_pkg::C_LF) begin
            chars[0] = c;
            n = 1;
            p = 7'd0;
        end else begin
            chars[0] = shown_as_is(c) ? c : tec_pkg::C_QMARK;
            n = 1;
            p = (p + 7'd1) % tw;
        end
        for (k = 0; k < n; k++) begin
            b.out_byte       = chars[k];
            b.run_last       = (k == n - 1);
            b.string_end     = (k == n - 1) && last;
            b.form_feed_seen = (k == n - 1) && last && ff_pending;
            display_q.push_back(b);
        end
        if (last) begin
            col_phase  = 6'd0;
            ff_pending = 1'b0;
        end else begin
            col_phase = p[5:0];
        end
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (text_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                next_item          = text_q.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.in_byte     <= next_item.ch;
                in_ch.string_last <= next_item.last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_chars++;
            if (out_ch.string_end) begin
                n_strings++;
            end
            if (display_q.size() == 0) begin
                flag_error($sformatf("unexpected beat, char %02h", out_ch.out_byte));
            end else begin
                if (out_ch.out_byte       !== display_q[0].out_byte   ||
                    out_ch.run_last       !== display_q[0].run_last   ||
                    out_ch.string_end     !== display_q[0].string_end ||
                    out_ch.form_feed_seen !== display_q[0].form_feed_seen) begin
                    flag_error($sformatf(
                        "beat %0d: got char %02h run %b end %b ff %b, exp %02h %b %b %b",
                        n_chars, out_ch.out_byte, out_ch.run_last, out_ch.string_end,
                        out_ch.form_feed_seen, display_q[0].out_byte,
                        display_q[0].run_last, display_q[0].string_end,
                        display_q[0].form_feed_seen));
                end
                void'(display_q.pop_front());
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            expand_byte(in_ch.in_byte, in_ch.string_last);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (text_q.size() == 0 && !in_ch.valid && display_q.size() == 0)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        unique case (idx)
            tec_pkg::CFG_TAB_WIDTH:  tab_width_r  = val;
            tec_pkg::CFG_BIG5_MODE:  big5_r       = val[0];
            tec_pkg::CFG_HIGH_PRINT: high_print_r = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(input logic [6:0] tw, input logic b5, input logic hp);
        write_reg(tec_pkg::CFG_TAB_WIDTH, tw);
        write_reg(tec_pkg::CFG_BIG5_MODE, {6'd0, b5});
        write_reg(tec_pkg::CFG_HIGH_PRINT, {6'd0, hp});
    endtask

    task automatic wait_drained();
        while (text_q.size() != 0 || in_ch.valid || display_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic add_byte(input logic [7:0] c, input logic last);
        t_text_item it;
        it.ch   = c;
        it.last = last;
        text_q.push_back(it);
        n_bytes++;
        if (c == tec_pkg::C_TAB) begin
            n_tabs++;
        end
    endtask

    function automatic logic [7:0] rand_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 10) return tec_pkg::C_TAB;
        if (r < 20) return 8'($urandom_range(31));
        if (r < 23) return tec_pkg::C_FF;
        if (r < 26) return tec_pkg::C_ESC;
        if (r < 32) return tec_pkg::C_LF;
        if (r < 44) return 8'($urandom_range(255, 128));
        if (r < 52) return 8'($urandom_range(255));
        return 8'($urandom_range(126, 32));
    endfunction

    // the final byte of each phase leaves the string open across the change
    task automatic add_random(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            add_byte(rand_text_byte(), (k != n - 1) && ($urandom_range(7) == 0));
        end
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = tec_pkg::CFG_TAB_WIDTH;
        i_cfg_data        = 7'd0;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = 8'h00;
        in_ch.string_last = 1'b0;
        out_ch.ready      = 1'b0;
        in_taken          = 1'b0;
        calm              = 1'b0;
        tab_width_r       = tec_pkg::C_TW_RESET;
        big5_r            = 1'b0;
        high_print_r      = 1'b0;
        col_phase         = 6'd0;
        ff_pending        = 1'b0;
        err_count         = 0;
        n_bytes           = 0;
        n_tabs            = 0;
        n_chars           = 0;
        n_strings         = 0;
        stall_cycles      = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: caret forms, high bytes and DEL as '?', form feed flag
        @(posedge i_clk);
        add_byte(8'h41, 1'b0);
        add_byte(tec_pkg::C_TAB, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(tec_pkg::C_FF, 1'b0);
        add_byte(tec_pkg::C_ESC, 1'b0);
        add_byte(8'h1F, 1'b0);
        add_byte(tec_pkg::C_LF, 1'b0);
        add_byte(tec_pkg::C_TAB, 1'b0);
        add_byte(tec_pkg::C_TILDE, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(tec_pkg::C_HIGH_LO, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(tec_pkg::C_TAB, 1'b1);
        add_random(50);
        wait_drained();

        // widest stops, ESC exempt, high bytes printable; no idling here
        configure(7'd64, 1'b1, 1'b1);
        @(posedge i_clk);
        calm = 1'b1;
        add_byte(tec_pkg::C_TAB, 1'b0);
        add_byte(tec_pkg::C_ESC, 1'b0);
        add_byte(tec_pkg::C_HIGH_LO, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h9F, 1'b0);
        add_byte(8'h78, 1'b0);
        add_byte(tec_pkg::C_TAB, 1'b1);
        add_random(50);
        wait_drained();
        calm = 1'b0;

        configure(7'd1, 1'b0, 1'b1);
        @(posedge i_clk);
        add_random(45);
        wait_drained();

        configure(7'd0, 1'b1, 1'b0);
        @(posedge i_clk);
        add_random(40);
        wait_drained();

        configure(7'd127, 1'b0, 1'b0);
        write_reg(CFG_UNUSED, 7'($urandom_range(127)));
        @(posedge i_clk);
        add_random(40);
        wait_drained();

        configure(7'd3, 1'b1, 1'b1);
        @(posedge i_clk);
        add_random(50);
        wait_drained();

        configure(7'd37, 1'b0, 1'b1);
        @(posedge i_clk);
        add_random(55);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (display_q.size() != 0) begin
            flag_error($sformatf("%0d display characters never arrived", display_q.size()));
        end
        $display("covered %0d text bytes (%0d tabs) over 7 register settings",
                 n_bytes, n_tabs);
        $display("checked %0d display characters, %0d completed strings", n_chars, n_strings);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
